/* src/bole_pkg.sv */
// Shared types and constants for the bounded ordered list engine.
package bole_pkg;

  localparam int KindW = 3;
  localparam int PortW = 32;

  localparam logic [KindW-1:0] KIND_APPEND = 3'd0;
  localparam logic [KindW-1:0] KIND_INSERT = 3'd1;
  localparam logic [KindW-1:0] KIND_ERASE  = 3'd2;
  localparam logic [KindW-1:0] KIND_READ   = 3'd3;
  localparam logic [KindW-1:0] KIND_FIND   = 3'd4;

  typedef struct packed {
    logic ins;
    logic ers;
  } cell_cmd_t;

endpackage

/* src/bole_cell.sv */
// One list slot: holds an entry, shifts with its neighbors, compares against the key.
module bole_cell #(
  parameter int IDX = 0,
  parameter int VW  = 32,
  parameter int CW  = 5
) (
  input  logic                clk,
  input  bole_pkg::cell_cmd_t cmd,
  input  logic [CW-1:0]       pos,
  input  logic [CW-1:0]       fill,
  input  logic [VW-1:0]       key,
  input  logic [VW-1:0]       left_val,
  input  logic [VW-1:0]       right_val,
  output logic [VW-1:0]       val,
  output logic                hit
);
  import bole_pkg::*;

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic [VW-1:0] val_next;
  logic          load;

  always_comb begin
    val_next = val;
    load     = 1'b0;
    if (cmd.ins) begin
      if (MyIdx == pos) begin
        val_next = key;
        load     = 1'b1;
      end else if (MyIdx > pos) begin
        val_next = left_val;
        load     = 1'b1;
      end
    end else if (cmd.ers) begin
      if (MyIdx >= pos) begin
        val_next = right_val;
        load     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val <= val_next;
    end
  end

  assign hit = (val == key) && (MyIdx < fill);

endmodule

/* src/bounded_ordered_list_engine.sv */
// Top level of the bounded ordered list engine: request decode, cell row, result register.
//
//   channel  signals                                   direction
//   in       in_valid in_stall kind position item_value  request beats in
//   out      out_valid out_stall read_data found_position found count error
//                                                       result beats out
//
// One request per cycle while the result is not stalled; its result is registered and shows the next cycle.
// Every cell at or past the position shifts or loads in the same cycle; cells below it hold.
// Reset clears the count and the result valid; entries are not cleared.
// A stalled result holds; a new request is taken in the cycle the result drains.
module bounded_ordered_list_engine #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bole_pkg::KindW-1:0]         kind,
  input  logic [$clog2(DEPTH+1)-1:0]         position,
  input  logic signed [bole_pkg::PortW-1:0]  item_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [bole_pkg::PortW-1:0]  read_data,
  output logic [$clog2(DEPTH)-1:0]           found_position,
  output logic                               found,
  output logic [$clog2(DEPTH+1)-1:0]         count,
  output logic                               error
);
  import bole_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int VW = VALUE_WIDTH;
  localparam int RW = (VW > PortW) ? VW : PortW;
  localparam logic [CW-1:0] Full = CW'(DEPTH);

  logic [CW-1:0]          fill;
  logic [CW-1:0]          fill_next;
  logic [CW-1:0]          pos_eff;
  logic                   accept;
  logic                   err;
  cell_cmd_t              cmd;
  logic [RW-1:0]          key_ext;
  logic [VW-1:0]          key;
  logic [VW-1:0]          vals [DEPTH];
  logic [DEPTH-1:0]       hits;
  logic [VW-1:0]          rd_val;
  logic signed [RW-1:0]   rd_ext;
  logic [IW-1:0]          fpos;
  logic                   fhit;
  logic [PortW-1:0]       rdata;

  assign accept  = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;
  assign key_ext = RW'($unsigned(item_value));
  assign key     = key_ext[VW-1:0];

  always_comb begin
    err       = 1'b0;
    fill_next = fill;
    pos_eff   = position;
    cmd       = '0;
    case (kind)
      KIND_APPEND: begin
        err     = (fill == Full);
        pos_eff = fill;
        cmd.ins = accept && !err;
      end
      KIND_INSERT: begin
        err     = (fill == Full) || (position > fill);
        cmd.ins = accept && !err;
      end
      KIND_ERASE: begin
        err     = (position >= fill);
        cmd.ers = accept && !err;
      end
      KIND_READ: err = (position >= fill);
      KIND_FIND: err = 1'b0;
      default:   err = 1'b1;
    endcase
    if (cmd.ins) begin
      fill_next = fill + CW'(1);
    end else if (cmd.ers) begin
      fill_next = fill - CW'(1);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VW-1:0] left_val;
    logic [VW-1:0] right_val;
    if (g == 0) begin : g_first
      assign left_val = vals[g];
    end else begin : g_left
      assign left_val = vals[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_val = vals[g];
    end else begin : g_right
      assign right_val = vals[g+1];
    end
    bole_cell #(
      .IDX (g),
      .VW  (VW),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (pos_eff),
      .fill      (fill),
      .key       (key),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (vals[g]),
      .hit       (hits[g])
    );
  end

  assign rd_val = vals[position[IW-1:0]];
  assign rd_ext = RW'($signed(rd_val));

  always_comb begin
    fpos = '0;
    fhit = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hits[i]) begin
        fpos = IW'(i);
        fhit = 1'b1;
      end
    end
  end

  always_comb begin
    rdata = '0;
    if (kind == KIND_READ && !err) begin
      rdata = rd_ext[PortW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data      <= rdata;
      found          <= (kind == KIND_FIND) && fhit;
      found_position <= ((kind == KIND_FIND) && fhit) ? fpos : '0;
      count          <= fill_next;
      error          <= err;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= Full)
    else $error("list count above depth");

  a_err_no_change: assert property (@(posedge clk) disable iff (rst)
    accept && err |=> $stable(fill))
    else $error("refused request changed the count");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    accept |=> count == fill)
    else $error("result count differs from list count");

  a_found_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> !error)
    else $error("find hit flagged as error");

endmodule

/* tb/sv/tb_bounded_ordered_list_engine.sv */
// Testbench for the bounded ordered list engine: a shadow list predicts every result beat.
`timescale 1ns / 100ps

module tb_bounded_ordered_list_engine;
  import bole_pkg::*;

  localparam int DEPTH = 16;
  localparam int LIMIT = 400000;
  localparam int PHASES = 14;
  localparam int PHASE_LEN = 100;

  typedef struct {
    logic signed [31:0] read_data;
    logic [3:0]         found_position;
    logic               found;
    logic [4:0]         count;
    logic               error;
  } list_result_t;

  class list_shadow;
    logic signed [31:0] store[DEPTH];
    int unsigned        n;
    list_result_t       pending_results[$];
    int unsigned        fails;

    function new();
      n = 0;
      fails = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void note_request(logic [2:0] k, logic [4:0] pos, logic signed [31:0] val);
      list_result_t r;
      r.read_data = '0;
      r.found_position = '0;
      r.found = 1'b0;
      r.error = 1'b0;
      case (k)
        KIND_APPEND: begin
          if (n >= DEPTH) begin
            r.error = 1'b1;
          end else begin
            store[n] = val;
            n++;
          end
        end
        KIND_INSERT: begin
          if (n >= DEPTH || pos > n) begin
            r.error = 1'b1;
          end else begin
            for (int i = n; i > pos; i--) store[i] = store[i-1];
            store[pos] = val;
            n++;
          end
        end
        KIND_ERASE: begin
          if (pos >= n) begin
            r.error = 1'b1;
          end else begin
            for (int i = pos; i + 1 < n; i++) store[i] = store[i+1];
            n--;
          end
        end
        KIND_READ: begin
          if (pos >= n) r.error = 1'b1;
          else r.read_data = store[pos];
        end
        KIND_FIND: begin
          for (int i = 0; i < n; i++) begin
            if (store[i] == val) begin
              r.found = 1'b1;
              r.found_position = i[3:0];
              break;
            end
          end
        end
        default: r.error = 1'b1;
      endcase
      r.count = n[4:0];
      pending_results = {pending_results, r};
    endfunction

    function void cmp(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
        fails++;
      end
    endfunction

    function void check_result(logic signed [31:0] rd, logic [3:0] fp, logic fd,
                               logic [4:0] cnt, logic err);
      list_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, read_data %h count %0d", $time, rd, cnt);
        fails++;
        return;
      end
      e = pending_results.pop_front();
      cmp("read_data", e.read_data, rd);
      cmp("found_position", 32'(e.found_position), 32'(fp));
      cmp("found", 32'(e.found), 32'(fd));
      cmp("count", 32'(e.count), 32'(cnt));
      cmp("error", 32'(e.error), 32'(err));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         kind;
  logic [4:0]         position;
  logic signed [31:0] item_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] read_data;
  logic [3:0]         found_position;
  logic               found;
  logic [4:0]         count;
  logic               error;

  list_shadow  sb = new();
  bit          calm;
  int unsigned cycles;

  bounded_ordered_list_engine #(.DEPTH(DEPTH), .VALUE_WIDTH(32)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .position(position), .item_value(item_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .found_position(found_position), .found(found),
    .count(count), .error(error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(read_data, found_position, found, count, error);
  end

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // receiver: random stall before each result beat
  initial begin
    int unsigned g;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      g = draw_gap();
      repeat (g) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_req(logic [2:0] k, logic [4:0] p, logic signed [31:0] v);
    int unsigned g;
    g = draw_gap();
    repeat (g) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    position <= p;
    item_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_request(k, p, v);
  endtask

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] pool[8];
    pool = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 42, -42, 32'sh5555_aaaa};
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic random_req(int unsigned mode);
    logic [2:0]         k;
    logic [4:0]         p;
    logic signed [31:0] v;
    int unsigned        roll;
    roll = $urandom_range(0, 99);
    case (mode)
      0: k = roll < 45 ? KIND_APPEND : roll < 75 ? KIND_INSERT : roll < 85 ? KIND_READ :
             roll < 95 ? KIND_FIND : KIND_ERASE;
      1: k = roll < 50 ? KIND_ERASE : roll < 65 ? KIND_READ : roll < 80 ? KIND_FIND :
             roll < 90 ? KIND_INSERT : KIND_APPEND;
      2: k = 3'($urandom_range(0, 4));
      default: k = 3'($urandom_range(0, 7));
    endcase
    if (mode == 3 || $urandom_range(0, 99) < 12) p = 5'($urandom_range(0, 31));
    else if (k == KIND_INSERT) p = 5'($urandom_range(0, sb.n));
    else p = sb.n == 0 ? 5'd0 : 5'($urandom_range(0, sb.n - 1));
    v = pick_value();
    if (k == KIND_FIND && sb.n > 0 && $urandom_range(0, 9) < 6)
      v = sb.store[$urandom_range(0, sb.n - 1)];
    send_req(k, p, v);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = '0;
    position = '0;
    item_value = '0;
    calm = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list, edge values, insert/erase bounds, unused kinds
    send_req(KIND_READ, 5'd0, 0);
    send_req(KIND_ERASE, 5'd0, 0);
    send_req(KIND_FIND, 5'd0, 0);
    send_req(KIND_APPEND, 5'd0, 32'sh8000_0000);
    send_req(KIND_APPEND, 5'd31, 32'sh7fff_ffff);
    send_req(KIND_APPEND, 5'd0, -1);
    send_req(KIND_APPEND, 5'd0, 0);
    send_req(KIND_INSERT, 5'd0, 5);
    send_req(KIND_INSERT, 5'd5, 7);
    send_req(KIND_INSERT, 5'd7, 9);
    send_req(KIND_INSERT, 5'd31, 9);
    send_req(KIND_READ, 5'd0, 0);
    send_req(KIND_READ, 5'd5, 0);
    send_req(KIND_READ, 5'd6, 0);
    send_req(KIND_READ, 5'd31, 0);
    send_req(KIND_FIND, 5'd0, 32'sh7fff_ffff);
    send_req(KIND_FIND, 5'd0, 7);
    send_req(KIND_FIND, 5'd0, 12345);
    send_req(KIND_ERASE, 5'd0, 0);
    send_req(KIND_ERASE, 5'd31, 0);
    send_req(KIND_ERASE, 5'd4, 0);
    send_req(3'd5, 5'd1, 1);
    send_req(3'd6, 5'd16, -1);
    send_req(3'd7, 5'd0, 32'sh8000_0000);

    for (int ph = 0; ph < PHASES; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_LEN; i++) random_req(ph < 4 ? ph : $urandom_range(0, 3));
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* bounded_ordered_list_engine.f */
src/bole_pkg.sv
src/bole_cell.sv
src/bounded_ordered_list_engine.sv
tb/sv/tb_bounded_ordered_list_engine.sv
